FILE: hw/rtl/ax25_kfp_pkg.sv
// ----------------------------------------------------------------------------
// ax25_kfp_pkg
// Shared constants, codes and the byte-wide CRC step for the KISS/AX.25
// frame parser.
// ----------------------------------------------------------------------------
package ax25_kfp_pkg;

   // frame geometry
   localparam int MAX_FRAME_BYTES_DEF = 512;
   localparam int CALLSIGN_BYTES      = 6;
   localparam int POS_DST_SSID        = CALLSIGN_BYTES + 1;
   localparam int POS_SOURCE_SSID     = 2 * CALLSIGN_BYTES + 2;
   localparam int POS_CONTROL         = 2 * CALLSIGN_BYTES + 3;
   localparam int POS_PID             = 2 * CALLSIGN_BYTES + 4;
   localparam int HDR_PLUS_FCS        = POS_PID + 2;

   // crc
   localparam logic [15:0] CRC_GEN = 16'hA001;

   // csr map
   localparam int          CSR_ADDR_W      = 3;
   localparam logic        CSR_IDX_MIN_LEN = 1'b0;
   localparam logic        CSR_IDX_KISS    = 1'b1;
   localparam logic [6:0]  MIN_LEN_RESET   = 7'd18;
   localparam logic [3:0]  KISS_CODE_RESET = 4'd0;

   // byte roles
   typedef logic [3:0] role_type;
   localparam role_type ROLE_KISS        = 4'd0;
   localparam role_type ROLE_DEST_CALL   = 4'd1;
   localparam role_type ROLE_DST_SSID    = 4'd2;
   localparam role_type ROLE_SRC_CALL    = 4'd3;
   localparam role_type ROLE_SOURCE_SSID = 4'd4;
   localparam role_type ROLE_CONTROL     = 4'd5;
   localparam role_type ROLE_PID         = 4'd6;
   localparam role_type ROLE_INFO        = 4'd7;
   localparam role_type ROLE_NONE        = 4'd8;

   // error causes
   typedef logic [2:0] err_type;
   localparam err_type ERR_OK        = 3'd0;
   localparam err_type ERR_SHORT     = 3'd1;
   localparam err_type ERR_CRC       = 3'd2;
   localparam err_type ERR_NOT_DATA  = 3'd3;
   localparam err_type ERR_I_SHORT   = 3'd4;
   localparam err_type ERR_S_HAS_DAT = 3'd5;

   // frame kinds
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_I = 2'd0;
   localparam kind_type KIND_S = 2'd1;
   localparam kind_type KIND_U = 2'd2;

   // verdict fields of one result beat
   typedef struct packed {
      err_type    error_cause;
      kind_type   frame_kind;
      logic       is_command;
      logic [2:0] receive_seq;
      logic [2:0] send_seq;
      logic       poll_final;
      logic [4:0] sub_type;
      logic [7:0] protocol_id;
   } verdict_type;

   // reflected crc-16, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_GEN) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/ax25_kiss_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// ax25_kiss_frame_parser_unit
// Streaming KISS/AX.25 deframer: CRC check, two-byte holdback, role tagging
// and an end-of-frame verdict.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                              | tuser      | tlast
//  req_     | in  | frame_byte                         | -          | is_last
//  rsp_     | out | decoded_value + verdict fields     | byte_role  | end_of_frame
//  csr_     | in  | min_frame_bytes @0, kiss_data_code @4 (APB)
//
//  One beat per cycle in both directions while not stalled; an accepted byte is
//  processed as taken, registering the result for the byte two before it.
//  The result register is the only buffer: a new byte is taken whenever it is
//  empty or being drained in the same cycle.
//  Synchronous active-high reset clears the frame state and loads the csr defaults.
// ----------------------------------------------------------------------------
module ax25_kiss_frame_parser_unit #(
   parameter int MAX_FRAME_BYTES = ax25_kfp_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input byte stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] frame_byte
   input  logic                                 req_tlast,
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] decoded_value, [10:8] error_cause, [12:11] frame_kind,
   // [13] is_command, [16:14] receive_seq, [19:17] send_seq, [20] poll_final,
   // [25:21] sub_type, [33:26] protocol_id, [39:34] zero
   output logic [39:0]                          rsp_tdata,
   output logic [3:0]                           rsp_tuser,  // [3:0] byte_role
   output logic                                 rsp_tlast,  // end_of_frame
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ax25_kfp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import ax25_kfp_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

   // csr
   logic [6:0]  min_len_ff, min_len_in;
   logic [3:0]  kiss_code_ff, kiss_code_in;
   logic        csr_wr;

   // frame state
   logic [15:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       held0_ff, held0_in, held1_ff, held1_in;
   logic [7:0]       kiss_ff, kiss_in, dssid_ff, dssid_in, sssid_ff, sssid_in;
   logic [7:0]       ctrl_ff, ctrl_in, pid_ff, pid_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_val_ff, rsp_val_in;
   role_type    rsp_role_ff, rsp_role_in;
   logic        rsp_last_ff, rsp_last_in;
   verdict_type rsp_vd_ff, rsp_vd_in;

   logic        req_acc;
   logic        emit;
   role_type    role;
   logic [7:0]  dec_val;
   logic [15:0] crc_nxt;
   logic [CNT_W-1:0] len;
   verdict_type vd;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      min_len_in   = min_len_ff;
      kiss_code_in = kiss_code_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            CSR_IDX_MIN_LEN: min_len_in   = csr_pwdata[6:0];
            CSR_IDX_KISS:    kiss_code_in = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_MIN_LEN: csr_prdata = {25'd0, min_len_ff};
         CSR_IDX_KISS:    csr_prdata = {28'd0, kiss_code_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // ---------------- byte path ----------------
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      emit = (cnt_ff >= CNT_W'(2)) || req_tlast;
      if (cnt_ff < CNT_W'(2))                                  role = ROLE_NONE;
      else if (cnt_ff == CNT_W'(2))                            role = ROLE_KISS;
      else if (cnt_ff <= CNT_W'(CALLSIGN_BYTES + 2))           role = ROLE_DEST_CALL;
      else if (cnt_ff == CNT_W'(POS_DST_SSID + 2))             role = ROLE_DST_SSID;
      else if (cnt_ff <  CNT_W'(POS_SOURCE_SSID + 2))          role = ROLE_SRC_CALL;
      else if (cnt_ff == CNT_W'(POS_SOURCE_SSID + 2))          role = ROLE_SOURCE_SSID;
      else if (cnt_ff == CNT_W'(POS_CONTROL + 2))              role = ROLE_CONTROL;
      else if (cnt_ff == CNT_W'(POS_PID + 2))                  role = ROLE_PID;
      else                                                     role = ROLE_INFO;

      case (role)
         ROLE_NONE:                        dec_val = 8'd0;
         ROLE_DEST_CALL, ROLE_SRC_CALL:    dec_val = {1'b0, held0_ff[7:1]};
         ROLE_DST_SSID, ROLE_SOURCE_SSID:  dec_val = {4'd0, held0_ff[4:1]};
         default:                          dec_val = held0_ff;
      endcase
   end

   assign crc_nxt = crc16_byte(crc_ff, req_tdata);

   always_comb begin
      kiss_in  = (cnt_ff == CNT_W'(0))               ? req_tdata : kiss_ff;
      dssid_in = (cnt_ff == CNT_W'(POS_DST_SSID))    ? req_tdata : dssid_ff;
      sssid_in = (cnt_ff == CNT_W'(POS_SOURCE_SSID)) ? req_tdata : sssid_ff;
      ctrl_in  = (cnt_ff == CNT_W'(POS_CONTROL))     ? req_tdata : ctrl_ff;
      pid_in   = (cnt_ff == CNT_W'(POS_PID))         ? req_tdata : pid_ff;
      len      = (cnt_ff < CNT_W'(MAX_FRAME_BYTES)) ? cnt_ff + CNT_W'(1) : cnt_ff;
   end

   // verdict from the state as updated by this byte
   always_comb begin
      vd = '0;
      if (16'(len) < 16'(min_len_ff)) begin
         vd.error_cause = ERR_SHORT;
      end else if (crc_nxt != 16'd0) begin
         vd.error_cause = ERR_CRC;
      end else if (!kiss_in[7] || (kiss_in[3:0] != kiss_code_ff)) begin
         vd.error_cause = ERR_NOT_DATA;
      end else begin
         vd.is_command = dssid_in[7] && !sssid_in[7];
         vd.poll_final = ctrl_in[4];
         if (!ctrl_in[0]) begin
            vd.frame_kind = KIND_I;
            if (len <= CNT_W'(HDR_PLUS_FCS)) begin
               vd.error_cause = ERR_I_SHORT;
            end else begin
               vd.receive_seq = ctrl_in[7:5];
               vd.send_seq    = ctrl_in[3:1];
               vd.protocol_id = pid_in;
            end
         end else if (!ctrl_in[1]) begin
            vd.frame_kind = KIND_S;
            if (len != CNT_W'(HDR_PLUS_FCS)) begin
               vd.error_cause = ERR_S_HAS_DAT;
            end else begin
               vd.receive_seq = ctrl_in[7:5];
               vd.sub_type    = {3'd0, ctrl_in[3:2]};
            end
         end else begin
            vd.frame_kind = KIND_U;
            vd.sub_type   = {ctrl_in[7:5], ctrl_in[3:2]};
         end
         if (vd.error_cause != ERR_OK) begin
            vd.poll_final = 1'b0;
         end
      end
   end

   // state next values
   always_comb begin
      crc_in   = crc_ff;
      cnt_in   = cnt_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      if (req_acc) begin
         if (req_tlast) begin
            crc_in   = 16'd0;
            cnt_in   = '0;
            held0_in = 8'd0;
            held1_in = 8'd0;
         end else begin
            crc_in   = crc_nxt;
            cnt_in   = len;
            held0_in = held1_ff;
            held1_in = req_tdata;
         end
      end
   end

   // output register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_val_in   = rsp_val_ff;
      rsp_role_in  = rsp_role_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_vd_in    = rsp_vd_ff;
      if (req_acc && emit) begin
         rsp_valid_in = 1'b1;
         rsp_val_in   = dec_val;
         rsp_role_in  = role;
         rsp_last_in  = req_tlast;
         rsp_vd_in    = req_tlast ? vd : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff   <= MIN_LEN_RESET;
         kiss_code_ff <= KISS_CODE_RESET;
         crc_ff       <= 16'd0;
         cnt_ff       <= '0;
         held0_ff     <= 8'd0;
         held1_ff     <= 8'd0;
         kiss_ff      <= 8'd0;
         dssid_ff     <= 8'd0;
         sssid_ff     <= 8'd0;
         ctrl_ff      <= 8'd0;
         pid_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_len_ff   <= min_len_in;
         kiss_code_ff <= kiss_code_in;
         crc_ff       <= crc_in;
         cnt_ff       <= cnt_in;
         held0_ff     <= held0_in;
         held1_ff     <= held1_in;
         if (req_acc) begin
            kiss_ff  <= req_tlast ? 8'd0 : kiss_in;
            dssid_ff <= req_tlast ? 8'd0 : dssid_in;
            sssid_ff <= req_tlast ? 8'd0 : sssid_in;
            ctrl_ff  <= req_tlast ? 8'd0 : ctrl_in;
            pid_ff   <= req_tlast ? 8'd0 : pid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_val_ff  <= rsp_val_in;
      rsp_role_ff <= rsp_role_in;
      rsp_last_ff <= rsp_last_in;
      rsp_vd_ff   <= rsp_vd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_role_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {6'd0, rsp_vd_ff.protocol_id, rsp_vd_ff.sub_type,
                        rsp_vd_ff.poll_final, rsp_vd_ff.send_seq,
                        rsp_vd_ff.receive_seq, rsp_vd_ff.is_command,
                        rsp_vd_ff.frame_kind, rsp_vd_ff.error_cause, rsp_val_ff};

   // ---------------- checks ----------------
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tlast) |=> (cnt_ff == '0) && (crc_ff == 16'd0))
      else $error("frame state not cleared after last beat");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_FRAME_BYTES))
      else $error("byte count past saturation");

   a_mid_no_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_vd_ff == '0))
      else $error("verdict fields set on mid-frame beat");

   a_early_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff &&
       (rsp_vd_ff.error_cause == ERR_SHORT || rsp_vd_ff.error_cause == ERR_CRC ||
        rsp_vd_ff.error_cause == ERR_NOT_DATA))
      |-> (rsp_vd_ff.frame_kind == KIND_I) && !rsp_vd_ff.is_command &&
          (rsp_vd_ff.sub_type == 5'd0) && (rsp_vd_ff.protocol_id == 8'd0))
      else $error("verdict detail present on header error");

   a_early_no_beat: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !req_tlast && (cnt_ff < CNT_W'(2)) && rsp_tready) |=> !rsp_valid_ff)
      else $error("result emitted before any byte was released");

endmodule
